// ----- rtl/tbi_pkg.sv -----
// Shared constants, status codes and pipeline side-band type for the triangle interpolator.
package tbi_pkg;

    localparam int DEF_COORD_BITS = 24;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int OUT_BITS       = 32;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_INSIDE     = 2'd0,
        STATUS_OUTSIDE    = 2'd1,
        STATUS_DEGENERATE = 2'd2
    } status_t;

    // Side-band that rides along with every transaction through the divider chain
    typedef struct packed {
        logic    neg;
        status_t status;
    } tbi_meta_t;

endpackage

// ----- rtl/tbi_front.sv -----
// Front pipeline: edge vectors, determinant, weight numerators, classification, dividend prep.
module tbi_front #(
    parameter int COORD_BITS = tbi_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = tbi_pkg::DEF_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_corner_a_x,
    input  logic signed [COORD_BITS-1:0] s_corner_a_y,
    input  logic signed [COORD_BITS-1:0] s_corner_a_z,
    input  logic signed [COORD_BITS-1:0] s_corner_b_x,
    input  logic signed [COORD_BITS-1:0] s_corner_b_y,
    input  logic signed [COORD_BITS-1:0] s_corner_b_z,
    input  logic signed [COORD_BITS-1:0] s_corner_c_x,
    input  logic signed [COORD_BITS-1:0] s_corner_c_y,
    input  logic signed [COORD_BITS-1:0] s_corner_c_z,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [COORD_BITS*3+FRAC_BITS+8:0] m_rem,
    output logic [2*COORD_BITS+3:0]      m_dvs,
    output logic signed [COORD_BITS-1:0] m_cz,
    output tbi_pkg::tbi_meta_t           m_meta
);

    localparam int DFW = COORD_BITS + 1;
    localparam int PW  = 2 * DFW;
    localparam int DW  = PW + 1;
    localparam int HL  = (DW + 1) / 2;
    localparam int HH  = DW - HL;
    localparam int LPW = HL + 1 + DFW;
    localparam int HPW = HH + DFW;
    localparam int NW  = DW + DFW + 1;
    localparam int TW  = NW + FRAC_BITS + 2;
    localparam int UW  = TW + 1;
    localparam int NST = 8;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;
    logic [NST-1:0] ld;

    // Ready chain: a stage takes data when empty or when its successor moves
    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        ld[0] = rdy[0] && s_valid;
        for (int i = 1; i < NST; i++) begin
            ld[i] = rdy[i] && v_reg[i-1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: edge and offset vectors
    logic signed [DFW-1:0] e0_reg, e1_reg, e2_reg, e3_reg, f_reg, px_reg, py_reg;
    logic signed [DFW-1:0] dza1_reg, dzb1_reg;
    logic signed [COORD_BITS-1:0] cz1_reg;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            e0_reg   <= DFW'(s_corner_b_y) - DFW'(s_corner_c_y);
            e1_reg   <= DFW'(s_corner_c_x) - DFW'(s_corner_b_x);
            e2_reg   <= DFW'(s_corner_c_y) - DFW'(s_corner_a_y);
            e3_reg   <= DFW'(s_corner_a_x) - DFW'(s_corner_c_x);
            f_reg    <= DFW'(s_corner_a_y) - DFW'(s_corner_c_y);
            px_reg   <= DFW'(s_query_x) - DFW'(s_corner_c_x);
            py_reg   <= DFW'(s_query_y) - DFW'(s_corner_c_y);
            dza1_reg <= DFW'(s_corner_a_z) - DFW'(s_corner_c_z);
            dzb1_reg <= DFW'(s_corner_b_z) - DFW'(s_corner_c_z);
            cz1_reg  <= s_corner_c_z;
        end
    end

    // Stage 2: cross products
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DFW-1:0] dza2_reg, dzb2_reg;
    logic signed [COORD_BITS-1:0] cz2_reg;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            p0_reg   <= e0_reg * e3_reg;
            p1_reg   <= e1_reg * f_reg;
            p2_reg   <= e0_reg * px_reg;
            p3_reg   <= e1_reg * py_reg;
            p4_reg   <= e2_reg * px_reg;
            p5_reg   <= e3_reg * py_reg;
            dza2_reg <= dza1_reg;
            dzb2_reg <= dzb1_reg;
            cz2_reg  <= cz1_reg;
        end
    end

    // Stage 3: determinant and weight numerators
    logic signed [DW-1:0] d3_reg, n13_reg, n23_reg;
    logic signed [DFW-1:0] dza3_reg, dzb3_reg;
    logic signed [COORD_BITS-1:0] cz3_reg;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            d3_reg   <= DW'(p0_reg) + DW'(p1_reg);
            n13_reg  <= DW'(p2_reg) + DW'(p3_reg);
            n23_reg  <= DW'(p4_reg) + DW'(p5_reg);
            dza3_reg <= dza2_reg;
            dzb3_reg <= dzb2_reg;
            cz3_reg  <= cz2_reg;
        end
    end

    // Stage 4: force a positive determinant and classify the query
    logic signed [DW-1:0] dn, n1n, n2n;
    logic signed [DW:0]   nsum;
    tbi_pkg::status_t     status_next;

    always_comb begin
        dn   = d3_reg[DW-1] ? -d3_reg  : d3_reg;
        n1n  = d3_reg[DW-1] ? -n13_reg : n13_reg;
        n2n  = d3_reg[DW-1] ? -n23_reg : n23_reg;
        nsum = (DW+1)'(n1n) + (DW+1)'(n2n);
        if (d3_reg == '0) begin
            status_next = tbi_pkg::STATUS_DEGENERATE;
        end else if (n1n < 0 || n2n < 0 || n1n > dn || n2n > dn ||
                     nsum > (DW+1)'(dn)) begin
            status_next = tbi_pkg::STATUS_OUTSIDE;
        end else begin
            status_next = tbi_pkg::STATUS_INSIDE;
        end
    end

    logic signed [DW-1:0] d4_reg, n14_reg, n24_reg;
    logic signed [DFW-1:0] dza4_reg, dzb4_reg;
    logic signed [COORD_BITS-1:0] cz4_reg;
    tbi_pkg::status_t st4_reg;

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            d4_reg   <= dn;
            n14_reg  <= n1n;
            n24_reg  <= n2n;
            dza4_reg <= dza3_reg;
            dzb4_reg <= dzb3_reg;
            cz4_reg  <= cz3_reg;
            st4_reg  <= status_next;
        end
    end

    // Stage 5: split weight-by-height products into narrow partial products
    logic signed [LPW-1:0] pla_reg, plb_reg;
    logic signed [HPW-1:0] pha_reg, phb_reg;
    logic signed [DW-1:0]  d5_reg;
    logic signed [COORD_BITS-1:0] cz5_reg;
    tbi_pkg::status_t st5_reg;

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            pla_reg <= $signed({1'b0, n14_reg[HL-1:0]}) * dza4_reg;
            pha_reg <= $signed(n14_reg[DW-1:HL]) * dza4_reg;
            plb_reg <= $signed({1'b0, n24_reg[HL-1:0]}) * dzb4_reg;
            phb_reg <= $signed(n24_reg[DW-1:HL]) * dzb4_reg;
            d5_reg  <= d4_reg;
            cz5_reg <= cz4_reg;
            st5_reg <= st4_reg;
        end
    end

    // Stage 6: weighted height numerator
    logic signed [NW-1:0] num_reg;
    logic signed [DW-1:0] d6_reg;
    logic signed [COORD_BITS-1:0] cz6_reg;
    tbi_pkg::status_t st6_reg;

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            num_reg <= (NW'(pha_reg) <<< HL) + NW'(pla_reg)
                     + (NW'(phb_reg) <<< HL) + NW'(plb_reg);
            d6_reg  <= d5_reg;
            cz6_reg <= cz5_reg;
            st6_reg <= st5_reg;
        end
    end

    // Stage 7: scale and add half a step for round to nearest
    logic signed [TW-1:0] t_reg;
    logic [DW:0]          dvs7_reg;
    logic signed [COORD_BITS-1:0] cz7_reg;
    tbi_pkg::status_t st7_reg;

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            t_reg    <= (TW'(num_reg) <<< (FRAC_BITS + 1)) + TW'(d6_reg);
            dvs7_reg <= {d6_reg, 1'b0};
            cz7_reg  <= cz6_reg;
            st7_reg  <= st6_reg;
        end
    end

    // Stage 8: fold a negative dividend so an unsigned divide yields the floor
    logic signed [UW-1:0] tx, dx, mag;

    always_comb begin
        tx  = UW'(t_reg);
        dx  = $signed(UW'(dvs7_reg));
        mag = t_reg[TW-1] ? (-tx + dx - UW'(1)) : tx;
    end

    logic [UW-1:0] rem_reg;
    logic [DW:0]   dvs_reg;
    logic signed [COORD_BITS-1:0] cz_reg;
    tbi_pkg::tbi_meta_t meta_reg;

    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            rem_reg         <= mag;
            dvs_reg         <= dvs7_reg;
            cz_reg          <= cz7_reg;
            meta_reg.neg    <= t_reg[TW-1];
            meta_reg.status <= st7_reg;
        end
    end

    // Widen the remainder by one bit to the divider chain width
    assign m_rem  = {1'b0, rem_reg};
    assign m_dvs  = dvs_reg;
    assign m_cz   = cz_reg;
    assign m_meta = meta_reg;

endmodule

// ----- rtl/tbi_div_cell.sv -----
// One restoring-division cell: resolves a single quotient bit and hands on the remainder.
module tbi_div_cell #(
    parameter int COORD_BITS = tbi_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = tbi_pkg::DEF_FRAC_BITS,
    parameter int BIT_POS    = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [COORD_BITS*3+FRAC_BITS+8:0] s_rem,
    input  logic [COORD_BITS+FRAC_BITS:0] s_quot,
    input  logic [2*COORD_BITS+3:0]      s_dvs,
    input  logic signed [COORD_BITS-1:0] s_cz,
    input  tbi_pkg::tbi_meta_t           s_meta,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [COORD_BITS*3+FRAC_BITS+8:0] m_rem,
    output logic [COORD_BITS+FRAC_BITS:0] m_quot,
    output logic [2*COORD_BITS+3:0]      m_dvs,
    output logic signed [COORD_BITS-1:0] m_cz,
    output tbi_pkg::tbi_meta_t           m_meta
);

    localparam int UW = COORD_BITS * 3 + FRAC_BITS + 9;
    localparam int QB = COORD_BITS + FRAC_BITS + 1;

    logic          v_reg;
    logic [UW-1:0] dsh;
    logic [UW:0]   trial;
    logic          take;
    logic [UW-1:0] rem_next;
    logic [QB-1:0] quot_next;

    assign s_ready = !v_reg || m_ready;

    // Trial subtract of the divisor aligned to this bit
    always_comb begin
        dsh       = UW'(s_dvs) << BIT_POS;
        trial     = {1'b0, s_rem} - {1'b0, dsh};
        take      = !trial[UW];
        rem_next  = take ? trial[UW-1:0] : s_rem;
        quot_next = s_quot;
        quot_next[BIT_POS] = take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (s_ready) begin
            v_reg <= s_valid;
        end
    end

    logic [UW-1:0] rem_reg;
    logic [QB-1:0] quot_reg;
    logic [2*COORD_BITS+3:0] dvs_reg;
    logic signed [COORD_BITS-1:0] cz_reg;
    tbi_pkg::tbi_meta_t meta_reg;

    // Advance payload with the transaction
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            dvs_reg  <= s_dvs;
            cz_reg   <= s_cz;
            meta_reg <= s_meta;
        end
    end

    assign m_valid = v_reg;
    assign m_rem   = rem_reg;
    assign m_quot  = quot_reg;
    assign m_dvs   = dvs_reg;
    assign m_cz    = cz_reg;
    assign m_meta  = meta_reg;

endmodule

// ----- rtl/tbi_back.sv -----
// Output stage: apply quotient sign, add corner height, clamp, and hold the result.
module tbi_back #(
    parameter int COORD_BITS = tbi_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = tbi_pkg::DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [COORD_BITS+FRAC_BITS:0]     s_quot,
    input  logic signed [COORD_BITS-1:0]      s_cz,
    input  tbi_pkg::tbi_meta_t                s_meta,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tbi_pkg::OUT_BITS-1:0] m_height_out,
    output logic [tbi_pkg::STATUS_BITS-1:0]   m_status
);

    localparam int HW  = COORD_BITS + FRAC_BITS + 3;
    localparam int HXW = (HW > tbi_pkg::OUT_BITS + 1) ? HW : tbi_pkg::OUT_BITS + 1;
    localparam logic signed [HXW-1:0] HMAX = (HXW'(1) <<< (tbi_pkg::OUT_BITS - 1)) - HXW'(1);
    localparam logic signed [HXW-1:0] HMIN = -HMAX - HXW'(1);

    logic signed [HW-1:0]  base;
    logic signed [HW-1:0]  qs;
    logic signed [HXW-1:0] hx;
    logic signed [tbi_pkg::OUT_BITS-1:0] height_next;
    logic v_reg;

    // Combine the corner height with the signed quotient and saturate; non-inside results give zero
    always_comb begin
        base = HW'(s_cz) <<< FRAC_BITS;
        qs   = $signed(HW'(s_quot));
        hx   = HXW'(s_meta.neg ? (base - qs) : (base + qs));
        if (s_meta.status != tbi_pkg::STATUS_INSIDE) begin
            height_next = '0;
        end else if (hx > HMAX) begin
            height_next = HMAX[tbi_pkg::OUT_BITS-1:0];
        end else if (hx < HMIN) begin
            height_next = HMIN[tbi_pkg::OUT_BITS-1:0];
        end else begin
            height_next = hx[tbi_pkg::OUT_BITS-1:0];
        end
    end

    assign s_ready = !v_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (s_ready) begin
            v_reg <= s_valid;
        end
    end

    logic signed [tbi_pkg::OUT_BITS-1:0] height_reg;
    logic [tbi_pkg::STATUS_BITS-1:0] status_reg;

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            height_reg <= height_next;
            status_reg <= s_meta.status;
        end
    end

    assign m_valid      = v_reg;
    assign m_height_out = height_reg;
    assign m_status     = status_reg;

endmodule

// ----- rtl/triangle_barycentric_interp.sv -----
// Top level: barycentric height interpolation over one triangle per transaction.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   s_ (in)  | s_valid / s_ready  | corner a/b/c x,y,z and query x,y
//   m_ (out) | m_valid / m_ready  | m_height_out (fixed point), m_status
//
// One transaction enters per cycle while the output is not stalled. The pipeline has
// 8 front stages, one divider cell per quotient bit and one output stage.
// The divider chain of COORD_BITS + FRAC_BITS + 1 cells sets the latency.
// Synchronous active-low reset clears every stage valid; data registers are not reset.
// Each stage moves when empty or when its successor moves, so bubbles close up under stall.
module triangle_barycentric_interp #(
    parameter int COORD_BITS = tbi_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = tbi_pkg::DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_corner_a_x,
    input  logic signed [COORD_BITS-1:0]        s_corner_a_y,
    input  logic signed [COORD_BITS-1:0]        s_corner_a_z,
    input  logic signed [COORD_BITS-1:0]        s_corner_b_x,
    input  logic signed [COORD_BITS-1:0]        s_corner_b_y,
    input  logic signed [COORD_BITS-1:0]        s_corner_b_z,
    input  logic signed [COORD_BITS-1:0]        s_corner_c_x,
    input  logic signed [COORD_BITS-1:0]        s_corner_c_y,
    input  logic signed [COORD_BITS-1:0]        s_corner_c_z,
    input  logic signed [COORD_BITS-1:0]        s_query_x,
    input  logic signed [COORD_BITS-1:0]        s_query_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tbi_pkg::OUT_BITS-1:0] m_height_out,
    output logic [tbi_pkg::STATUS_BITS-1:0]     m_status
);

    localparam int UW = COORD_BITS * 3 + FRAC_BITS + 9;
    localparam int DVW = 2 * COORD_BITS + 4;
    localparam int QB = COORD_BITS + FRAC_BITS + 1;

    logic               c_valid [QB+1];
    logic               c_ready [QB+1];
    logic [UW-1:0]      c_rem   [QB+1];
    logic [QB-1:0]      c_quot  [QB+1];
    logic [DVW-1:0]     c_dvs   [QB+1];
    logic signed [COORD_BITS-1:0] c_cz [QB+1];
    tbi_pkg::tbi_meta_t c_meta  [QB+1];

    // Front stages feed the head of the divider chain
    tbi_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_corner_a_x(s_corner_a_x),
        .s_corner_a_y(s_corner_a_y),
        .s_corner_a_z(s_corner_a_z),
        .s_corner_b_x(s_corner_b_x),
        .s_corner_b_y(s_corner_b_y),
        .s_corner_b_z(s_corner_b_z),
        .s_corner_c_x(s_corner_c_x),
        .s_corner_c_y(s_corner_c_y),
        .s_corner_c_z(s_corner_c_z),
        .s_query_x   (s_query_x),
        .s_query_y   (s_query_y),
        .m_valid     (c_valid[0]),
        .m_ready     (c_ready[0]),
        .m_rem       (c_rem[0]),
        .m_dvs       (c_dvs[0]),
        .m_cz        (c_cz[0]),
        .m_meta      (c_meta[0])
    );

    assign c_quot[0] = '0;

    // Divider chain, most significant quotient bit first
    for (genvar j = 0; j < QB; j++) begin : g_cell
        tbi_div_cell #(
            .COORD_BITS(COORD_BITS),
            .FRAC_BITS (FRAC_BITS),
            .BIT_POS   (QB - 1 - j)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .s_valid(c_valid[j]),
            .s_ready(c_ready[j]),
            .s_rem  (c_rem[j]),
            .s_quot (c_quot[j]),
            .s_dvs  (c_dvs[j]),
            .s_cz   (c_cz[j]),
            .s_meta (c_meta[j]),
            .m_valid(c_valid[j+1]),
            .m_ready(c_ready[j+1]),
            .m_rem  (c_rem[j+1]),
            .m_quot (c_quot[j+1]),
            .m_dvs  (c_dvs[j+1]),
            .m_cz   (c_cz[j+1]),
            .m_meta (c_meta[j+1])
        );
    end

    tbi_back #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (c_valid[QB]),
        .s_ready     (c_ready[QB]),
        .s_quot      (c_quot[QB]),
        .s_cz        (c_cz[QB]),
        .s_meta      (c_meta[QB]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_height_out(m_height_out),
        .m_status    (m_status)
    );

`ifndef NO_ASSERTIONS
    // Non-inside results carry a zero height
    a_zero_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != tbi_pkg::STATUS_INSIDE |-> m_height_out == '0)
        else $error("non-inside result with nonzero height");

    // A free output lets the whole chain move, so the input must be ready
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is free");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented right after reset");
`endif

endmodule

// ----- tb/triangle_barycentric_interp_test.sv -----
// Self-checking testbench for the barycentric triangle height interpolator.
module triangle_barycentric_interp_test;

    localparam int CB = tbi_pkg::DEF_COORD_BITS;
    localparam int FB = tbi_pkg::DEF_FRAC_BITS;
    localparam int OB = tbi_pkg::OUT_BITS;
    localparam int LATENCY = CB + FB + 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;
    typedef struct packed {
        coord_t ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy;
    } tri_query_t;
    typedef struct packed {
        logic signed [OB-1:0] height;
        tbi_pkg::status_t     status;
    } height_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tri_query_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OB-1:0] m_height_out;
    logic [tbi_pkg::STATUS_BITS-1:0] m_status;

    height_result_t expected_heights[$];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  error_count = 0;
    longint cycle_count = 0;

    triangle_barycentric_interp DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_corner_a_x(s_item.ax), .s_corner_a_y(s_item.ay), .s_corner_a_z(s_item.az),
        .s_corner_b_x(s_item.bx), .s_corner_b_y(s_item.by), .s_corner_b_z(s_item.bz),
        .s_corner_c_x(s_item.cx), .s_corner_c_y(s_item.cy), .s_corner_c_z(s_item.cz),
        .s_query_x(s_item.qx), .s_query_y(s_item.qy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_height_out(m_height_out), .m_status(m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Compute the exact interpolated height in 128-bit integers
    function automatic height_result_t interp_height(tri_query_t t);
        logic signed [127:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy;
        logic signed [127:0] e0, e1, e2, e3, px, py, det, n1, n2, num, tnum, q, h, d2;
        height_result_t r;
        ax = t.ax; ay = t.ay; az = t.az; bx = t.bx; by = t.by; bz = t.bz;
        cx = t.cx; cy = t.cy; cz = t.cz; qx = t.qx; qy = t.qy;
        e0 = by - cy; e1 = cx - bx; e2 = cy - ay; e3 = ax - cx;
        px = qx - cx; py = qy - cy;
        det = e0 * e3 + e1 * (ay - cy);
        n1 = e0 * px + e1 * py;
        n2 = e2 * px + e3 * py;
        r.height = '0;
        if (det == 0) begin
            r.status = tbi_pkg::STATUS_DEGENERATE;
            return r;
        end
        if (det < 0) begin
            det = -det; n1 = -n1; n2 = -n2;
        end
        if (n1 < 0 || n2 < 0 || n1 > det || n2 > det || n1 + n2 > det) begin
            r.status = tbi_pkg::STATUS_OUTSIDE;
            return r;
        end
        num = n1 * (az - cz) + n2 * (bz - cz);
        tnum = (num <<< (FB + 1)) + det;
        d2 = det <<< 1;
        // floor division for a positive divisor
        q = tnum / d2;
        if (tnum < 0 && q * d2 != tnum) q = q - 1;
        h = (cz <<< FB) + q;
        if (h < -128'sd2147483648) h = -128'sd2147483648;
        if (h > 128'sd2147483647) h = 128'sd2147483647;
        r.height = h[OB-1:0];
        r.status = tbi_pkg::STATUS_INSIDE;
        return r;
    endfunction

    // Offer one transaction and hold it until accepted; valid stays up for a follow-on
    task automatic send_query(tri_query_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item <= t;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_heights.insert(expected_heights.size(), interp_height(t));
        @(negedge aclk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return $urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            2: return coord_t'(int'($urandom_range(64)) - 32);
            default: return coord_t'(int'($urandom_range(4095)) - 2048);
        endcase
    endfunction

    // Random corners; mostly the query is a weighted mean of the corners to land inside often, at times c equals b
    function automatic tri_query_t rand_query();
        tri_query_t t;
        int wa, wb, wc, s;
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
        t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
        t.qx = rand_coord(); t.qy = rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                wa = $urandom_range(100); wb = $urandom_range(100); wc = $urandom_range(100);
                s = wa + wb + wc + 1;
                t.qx = coord_t'((longint'(t.ax) * wa + longint'(t.bx) * wb
                                 + longint'(t.cx) * wc) / s);
                t.qy = coord_t'((longint'(t.ay) * wa + longint'(t.by) * wb
                                 + longint'(t.cy) * wc) / s);
            end
            6: begin
                t.cx = t.bx; t.cy = t.by;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic tri_query_t make_query(int ax, int ay, int az, int bx, int by, int bz,
                                              int cx, int cy, int cz, int qx, int qy);
        tri_query_t t;
        t.ax = coord_t'(ax); t.ay = coord_t'(ay); t.az = coord_t'(az);
        t.bx = coord_t'(bx); t.by = coord_t'(by); t.bz = coord_t'(bz);
        t.cx = coord_t'(cx); t.cy = coord_t'(cy); t.cz = coord_t'(cz);
        t.qx = coord_t'(qx); t.qy = coord_t'(qy);
        return t;
    endfunction

    // Drop valid and hold the sender until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_heights.size() != 0) @(negedge aclk);
    endtask

    // Directed: inside, edges, corners, outside, degenerate, ties, extremes
    task automatic test_directed();
        int mx, mn;
        mx = 8388607; mn = -8388608;
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, 3, 3));
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, 5, 5));
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, 10, 0));
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, 0, 0));
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, 6, 6));
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, -1, 2));
        send_query(make_query(0, 0, 100, 10, 0, 200, 0, 10, 300, 2, -1));
        send_query(make_query(0, 10, 1, 10, 0, 2, 0, 0, 3, 1, 1));
        send_query(make_query(0, 0, 5, 5, 5, 6, 10, 10, 7, 3, 3));
        send_query(make_query(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        send_query(make_query(0, 0, 0, 3, 0, 1, 0, 3, 0, 1, 1));
        send_query(make_query(0, 0, 0, 3, 0, -1, 0, 3, 0, 1, 1));
        send_query(make_query(0, 0, 0, 2, 0, 1, 0, 2, 0, 1, 0));
        send_query(make_query(0, 0, 0, 2, 0, -1, 0, 2, 0, 1, 0));
        send_query(make_query(mn, mn, mx, mx, mn, mn, mn, mx, mx, 0, 0));
        send_query(make_query(mn, mn, mn, mx, mn, mx, mn, mx, mn, mn, mn));
        send_query(make_query(mx, mx, mx, mn, mx, mn, mx, mn, mx, mx, mx));
        send_query(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mx, 0, 0));
        send_query(make_query(mn, mn, mx, mx, mn, mn, mn, mx, mx, mx, mx));
        send_query(make_query(mx, mn, mn, mx, mn, mn, mx, mn, mn, mx, mn));
        send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        wait_drained();
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_query(rand_query());
    endtask

    // Hold the output off long enough to fill the pipeline and stall input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_hold = 1'b1;
        repeat (LATENCY + 30) send_query(rand_query());
        recv_hold = 1'b0;
        wait_drained();
    endtask

    // Receiver: random stalls plus a counted long hold-off
    initial begin
        int hold_cycles;
        forever begin
            @(negedge aclk);
            if (recv_hold) begin
                m_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 3 * LATENCY) begin
                    @(negedge aclk);
                    hold_cycles++;
                end
                m_ready <= 1'b1;
                while (recv_hold) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check each result against the oldest expected height
    initial begin
        height_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_heights.size() == 0) begin
                    $display("%0t: unexpected result height %0d status %0d",
                             $time, m_height_out, m_status);
                    error_count++;
                end else begin
                    exp_r = expected_heights.pop_front();
                    if (m_height_out !== exp_r.height) begin
                        $display("%0t: height expected %0d actual %0d",
                                 $time, exp_r.height, m_height_out);
                        error_count++;
                    end
                    if (m_status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(170, 16, 53);
        test_backpressure();
        test_random(170, 53, 16);
        wait_drained();
        test_random(170, 0, 0);
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0 && expected_heights.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tbi_pkg.sv
rtl/tbi_front.sv
rtl/tbi_div_cell.sv
rtl/tbi_back.sv
rtl/triangle_barycentric_interp.sv
tb/triangle_barycentric_interp_test.sv
